>>> rtl/sle_pkg.sv
// Shared types and constants for the sequential list engine.
`timescale 1ns / 1ps

package sle_pkg;

    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int S_DATA_W = 40;   // position, value_in, zero pad
    localparam int M_DATA_W = 48;   // value_out, found_position, list_length, list_empty, pad

    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load_req;     // latch a new request, clear result
        logic rd_pos;       // read entry at position-1
        logic rd_idx;       // read entry at idx
        logic rd_idx_m1;    // read entry at idx-1
        logic wr_move_up;   // entry[idx] <= read data
        logic wr_move_dn;   // entry[idx-1] <= read data
        logic wr_val;       // entry[position-1] <= value
        logic idx_clr;
        logic idx_from_cnt;
        logic idx_from_pos;
        logic idx_inc;
        logic idx_dec;
        logic set_err;
        logic cap_vout;
        logic cap_found;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic load_out;
    } sle_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad;       // request fails its bounds check or has an unknown op
        logic            cnt_full;
        logic            ins_more;  // idx >= position
        logic            idx_lt_cnt;
        logic            match;     // read data equals key
        logic            out_free;
    } sle_stat_t;

endpackage

>>> rtl/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sle_datapath.sv
// Datapath: request registers, length count, index, entry RAM and output register.
`timescale 1ns / 1ps

module sle_datapath import sle_pkg::*; #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [OP_W-1:0]     req_type,
    input  logic [POS_W-1:0]    position,
    input  logic [VAL_W-1:0]    value_in,
    input  sle_cmd_t            cmd,
    output sle_stat_t           st,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [0:0]          m_tuser
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [OP_W-1:0]        op_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          idx_reg;
    logic                   res_status_reg;
    logic [VAL_W-1:0]       res_vout_reg;
    logic [POS_W-1:0]       res_found_reg;
    logic                   m_tvalid_reg;
    logic [M_DATA_W-1:0]    m_tdata_reg;
    logic [0:0]             m_tuser_reg;

    logic [VALUE_WIDTH+VAL_W-1:0] vin_ext;
    logic [VALUE_WIDTH+VAL_W-1:0] rd_ext;
    logic [VALUE_WIDTH-1:0]       rdata;
    logic [CMPW-1:0]              pos_x;
    logic [CMPW-1:0]              pos_m1;
    logic [CMPW-1:0]              cnt_x;
    logic [CMPW-1:0]              idx_x;
    logic [CMPW-1:0]              found_x;
    logic [CW-1:0]                idx_m1;
    logic                         get_ok;
    logic                         ins_ok;
    logic                         bad;
    logic                         ram_we;
    logic                         ram_re;
    logic [AW-1:0]                waddr;
    logic [AW-1:0]                raddr;
    logic [VALUE_WIDTH-1:0]       wdata;
    logic [M_DATA_W-1:0]          m_tdata_next;

    assign vin_ext = {{VALUE_WIDTH{1'b0}}, value_in};
    assign rd_ext  = {{VAL_W{1'b0}}, rdata};
    assign pos_x   = CMPW'(pos_reg);
    assign pos_m1  = pos_x - CMPW'(1);
    assign cnt_x   = CMPW'(count_reg);
    assign idx_x   = CMPW'(idx_reg);
    assign found_x = idx_x + CMPW'(1);
    assign idx_m1  = idx_reg - CW'(1);

    assign get_ok = (pos_reg != '0) && (pos_m1 < cnt_x);
    assign ins_ok = (count_reg < CW'(CAPACITY)) && (pos_reg != '0) && (pos_m1 <= cnt_x);

    always_comb
    begin
        case (op_reg)
            OP_GET, OP_DELETE:   bad = !get_ok;
            OP_LOCATE, OP_CLEAR: bad = 1'b0;
            OP_INSERT:           bad = !ins_ok;
            default:             bad = 1'b1;
        endcase
    end

    // entry RAM addressing
    assign ram_we = cmd.wr_move_up | cmd.wr_move_dn | cmd.wr_val;
    assign ram_re = cmd.rd_pos | cmd.rd_idx | cmd.rd_idx_m1;
    assign wdata  = cmd.wr_val ? val_reg : rdata;

    always_comb
    begin
        if (cmd.wr_val)
        begin
            waddr = pos_m1[AW-1:0];
        end
        else if (cmd.wr_move_dn)
        begin
            waddr = idx_m1[AW-1:0];
        end
        else
        begin
            waddr = idx_reg[AW-1:0];
        end
    end

    always_comb
    begin
        if (cmd.rd_pos)
        begin
            raddr = pos_m1[AW-1:0];
        end
        else if (cmd.rd_idx_m1)
        begin
            raddr = idx_m1[AW-1:0];
        end
        else
        begin
            raddr = idx_reg[AW-1:0];
        end
    end

    sle_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end

            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg         <= req_type;
            pos_reg        <= position;
            val_reg        <= vin_ext[VALUE_WIDTH-1:0];
            res_status_reg <= 1'b0;
            res_vout_reg   <= '0;
            res_found_reg  <= '0;
        end
        else
        begin
            if (cmd.set_err)
            begin
                res_status_reg <= 1'b1;
            end
            if (cmd.cap_vout)
            begin
                res_vout_reg <= rd_ext[VAL_W-1:0];
            end
            if (cmd.cap_found)
            begin
                res_found_reg <= found_x[POS_W-1:0];
            end
        end

        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_from_cnt)
        begin
            idx_reg <= count_reg;
        end
        else if (cmd.idx_from_pos)
        begin
            idx_reg <= pos_x[CW-1:0];
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + CW'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_m1;
        end

        if (cmd.load_out)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tdata_next = {1'b0, (count_reg == '0), cnt_x[POS_W-1:0], res_found_reg, res_vout_reg};

    assign st.op         = op_reg;
    assign st.bad        = bad;
    assign st.cnt_full   = (count_reg == CW'(CAPACITY));
    assign st.ins_more   = (idx_x >= pos_x);
    assign st.idx_lt_cnt = (idx_reg < count_reg);
    assign st.match      = (rdata == val_reg);
    assign st.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/sle_ctrl.sv
// Controller state machine: sequences RAM reads, shifts and scans for each request.
`timescale 1ns / 1ps

module sle_ctrl import sle_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  sle_stat_t st,
    output sle_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_GET_CAP = 4'd2;
    localparam logic [3:0] S_LOC_RD  = 4'd3;
    localparam logic [3:0] S_LOC_CMP = 4'd4;
    localparam logic [3:0] S_INS_RD  = 4'd5;
    localparam logic [3:0] S_INS_WR  = 4'd6;
    localparam logic [3:0] S_DEL_CAP = 4'd7;
    localparam logic [3:0] S_DEL_RD  = 4'd8;
    localparam logic [3:0] S_DEL_WR  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.bad)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    case (st.op)
                        OP_GET:
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_GET_CAP;
                        end
                        OP_LOCATE:
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_LOC_RD;
                        end
                        OP_INSERT:
                        begin
                            cmd.idx_from_cnt = 1'b1;
                            state_next       = S_INS_RD;
                        end
                        OP_DELETE:
                        begin
                            cmd.rd_pos       = 1'b1;
                            cmd.idx_from_pos = 1'b1;
                            state_next       = S_DEL_CAP;
                        end
                        OP_CLEAR:
                        begin
                            cmd.cnt_clr = 1'b1;
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_GET_CAP:
            begin
                cmd.cap_vout = 1'b1;
                state_next   = S_DONE;
            end
            S_LOC_RD:
            begin
                if (st.idx_lt_cnt)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_LOC_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LOC_CMP:
            begin
                if (st.match)
                begin
                    cmd.cap_found = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_LOC_RD;
                end
            end
            // shift up from the tail, then drop the new value in
            S_INS_RD:
            begin
                if (st.ins_more)
                begin
                    cmd.rd_idx_m1 = 1'b1;
                    state_next    = S_INS_WR;
                end
                else
                begin
                    cmd.wr_val  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_move_up = 1'b1;
                cmd.idx_dec    = 1'b1;
                state_next     = S_INS_RD;
            end
            S_DEL_CAP:
            begin
                cmd.cap_vout = 1'b1;
                state_next   = S_DEL_RD;
            end
            // shift down toward the removed slot
            S_DEL_RD:
            begin
                if (st.idx_lt_cnt)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_DEL_WR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DEL_WR:
            begin
                cmd.wr_move_dn = 1'b1;
                cmd.idx_inc    = 1'b1;
                state_next     = S_DEL_RD;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/sequential_list_engine.sv
// Top level: bounded ordered list engine, streaming request in, result out.
// Operation: locate scans the entries one by one; insert and delete shift the entries
//   one at a time through the single read and single write port of the entry RAM.
// Throughput: one transaction at a time; the next is taken once the result is loaded.
// Reset: rst_n asynchronous, active low; clears length and output valid, entries undefined.
`timescale 1ns / 1ps

module sequential_list_engine import sle_pkg::*; #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // position[6:0], value_in[38:7], pad
    input  logic [OP_W-1:0]     s_tuser,   // req_type[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // value_out[31:0], found_position[38:32],
                                           // list_length[45:39], list_empty[46], pad
    output logic [0:0]          m_tuser    // status[0]
);

    sle_cmd_t  cmd;
    sle_stat_t st;

    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sle_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_type (s_tuser),
        .position (s_tdata[POS_W-1:0]),
        .value_in (s_tdata[POS_W+VAL_W-1:POS_W]),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_move_up, cmd.wr_move_dn, cmd.wr_val}))
        else $error("more than one RAM write in a cycle");

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new transaction taken while one is in flight");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !st.cnt_full)
        else $error("length grows past capacity");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[38:0] == 39'd0))
        else $error("error result carries data");
`endif

endmodule
